@@ rtl/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// rti_pkg
// Widths, register indexes and constants of the ray / triangle intersection
// pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int FRAC_BITS = 16;          // fraction bits of t
    localparam int BARY_FRAC = 16;          // fraction bits of the barycentrics
    localparam int VW        = 32;          // coordinate width
    localparam int EW        = VW + 1;      // edge and offset width
    localparam int CW1       = VW + EW;     // d x e2 product width
    localparam int CW2       = 2 * EW;      // s x e1 product width
    localparam int PW        = CW2 + 1;     // cross vector element width
    localparam int HW        = PW - EW;     // upper slice of a cross element
    localparam int DW        = PW + EW + 2; // dot product width
    localparam int LW        = DW + FRAC_BITS;
    localparam int QB        = VW + 1;      // quotient bits of t
    localparam int BQB       = BARY_FRAC + 1;
    localparam int RW        = LW + QB;     // divider compare width
    localparam int NDIV      = QB;          // divider stages
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = $clog2(CFG_NUM);
    localparam int BW        = BARY_FRAC + 1;

    localparam logic signed [VW-1:0] DIR_Z_RST  = VW'(1) <<< FRAC_BITS;
    localparam logic signed [VW-1:0] T_FAR_RST  = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] DIST_MAX   = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] DIST_MIN   = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_T_NEAR   = 3'd6,
        REG_T_FAR    = 3'd7
    } cfg_reg_t;

endpackage

@@ rtl/ray_triangle_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Pipelined Moller-Trumbore test of one triangle per cycle against a ray and
// an open distance window held in registers.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_        in   s_valid / s_ready    s_v0_x .. s_v2_z (triangle vertices)
//  m_        out  m_valid / m_ready    m_hit, m_degenerate, m_hit_distance,
//                                      m_bary_beta, m_bary_gamma
//  cfg_      in   cfg_wr_en            cfg_index, cfg_wdata (no read-back)
//
//  one transfer per cycle sustained; 8 stages of edges, cross products, split
//  multiplies, joins, dot sums, sign fix and set-up, then a 33 stage restoring
//  divider (one quotient bit per stage for t, and for beta and gamma in the
//  first BQB stages) and the output register. the whole pipe moves on one
//  enable, held only while the output register holds an untaken result.
//  synchronous reset clears the valid bits and loads register reset values.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rti_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rti_pkg::VW-1:0]             cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [rti_pkg::VW-1:0]      s_v0_x,
    input  logic signed [rti_pkg::VW-1:0]      s_v0_y,
    input  logic signed [rti_pkg::VW-1:0]      s_v0_z,
    input  logic signed [rti_pkg::VW-1:0]      s_v1_x,
    input  logic signed [rti_pkg::VW-1:0]      s_v1_y,
    input  logic signed [rti_pkg::VW-1:0]      s_v1_z,
    input  logic signed [rti_pkg::VW-1:0]      s_v2_x,
    input  logic signed [rti_pkg::VW-1:0]      s_v2_y,
    input  logic signed [rti_pkg::VW-1:0]      s_v2_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic                               m_degenerate,
    output logic signed [rti_pkg::VW-1:0]      m_hit_distance,
    output logic [rti_pkg::BW-1:0]             m_bary_beta,
    output logic [rti_pkg::BW-1:0]             m_bary_gamma
);

    localparam int VW   = rti_pkg::VW;
    localparam int EW   = rti_pkg::EW;
    localparam int CW1  = rti_pkg::CW1;
    localparam int CW2  = rti_pkg::CW2;
    localparam int PW   = rti_pkg::PW;
    localparam int DW   = rti_pkg::DW;
    localparam int LW   = rti_pkg::LW;
    localparam int QB   = rti_pkg::QB;
    localparam int BQB  = rti_pkg::BQB;
    localparam int RW   = rti_pkg::RW;
    localparam int NDIV = rti_pkg::NDIV;
    localparam int FB   = rti_pkg::FRAC_BITS;
    localparam int BF   = rti_pkg::BARY_FRAC;

    // rejoin one split product: upper slice weighted by 2^EW
    function automatic logic signed [DW-1:0] join_pp(input logic signed [PW-1:0] hi,
                                                     input logic signed [PW-1:0] lo);
        logic signed [DW-1:0] h;
        logic signed [DW-1:0] l;
        h = {{(DW-PW){hi[PW-1]}}, hi};
        l = {{(DW-PW){lo[PW-1]}}, lo};
        join_pp = (h <<< EW) + l;
    endfunction

    logic adv;

    // ---------------- configuration ----------------
    logic signed [VW-1:0] cfg_reg [rti_pkg::CFG_NUM];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[rti_pkg::REG_ORIGIN_X] <= '0;
            cfg_reg[rti_pkg::REG_ORIGIN_Y] <= '0;
            cfg_reg[rti_pkg::REG_ORIGIN_Z] <= '0;
            cfg_reg[rti_pkg::REG_DIR_X]    <= '0;
            cfg_reg[rti_pkg::REG_DIR_Y]    <= '0;
            cfg_reg[rti_pkg::REG_DIR_Z]    <= rti_pkg::DIR_Z_RST;
            cfg_reg[rti_pkg::REG_T_NEAR]   <= '0;
            cfg_reg[rti_pkg::REG_T_FAR]    <= rti_pkg::T_FAR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rti_pkg::REG_ORIGIN_X: cfg_reg[rti_pkg::REG_ORIGIN_X] <= cfg_wdata;
                rti_pkg::REG_ORIGIN_Y: cfg_reg[rti_pkg::REG_ORIGIN_Y] <= cfg_wdata;
                rti_pkg::REG_ORIGIN_Z: cfg_reg[rti_pkg::REG_ORIGIN_Z] <= cfg_wdata;
                rti_pkg::REG_DIR_X:    cfg_reg[rti_pkg::REG_DIR_X]    <= cfg_wdata;
                rti_pkg::REG_DIR_Y:    cfg_reg[rti_pkg::REG_DIR_Y]    <= cfg_wdata;
                rti_pkg::REG_DIR_Z:    cfg_reg[rti_pkg::REG_DIR_Z]    <= cfg_wdata;
                rti_pkg::REG_T_NEAR:   cfg_reg[rti_pkg::REG_T_NEAR]   <= cfg_wdata;
                rti_pkg::REG_T_FAR:    cfg_reg[rti_pkg::REG_T_FAR]    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic signed [VW-1:0] org [3];
    logic signed [VW-1:0] dir [3];
    assign org[0] = cfg_reg[rti_pkg::REG_ORIGIN_X];
    assign org[1] = cfg_reg[rti_pkg::REG_ORIGIN_Y];
    assign org[2] = cfg_reg[rti_pkg::REG_ORIGIN_Z];
    assign dir[0] = cfg_reg[rti_pkg::REG_DIR_X];
    assign dir[1] = cfg_reg[rti_pkg::REG_DIR_Y];
    assign dir[2] = cfg_reg[rti_pkg::REG_DIR_Z];

    // ---------------- valid chain of the front stages ----------------
    logic [6:0] vld_reg;
    logic       dvld_reg [NDIV+1];
    logic       m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[5:0], s_valid};
        end
    end

    // ---------------- stage 1: edges and offset ----------------
    logic signed [VW-1:0] v0 [3];
    logic signed [VW-1:0] v1 [3];
    logic signed [VW-1:0] v2 [3];
    assign v0[0] = s_v0_x; assign v0[1] = s_v0_y; assign v0[2] = s_v0_z;
    assign v1[0] = s_v1_x; assign v1[1] = s_v1_y; assign v1[2] = s_v1_z;
    assign v2[0] = s_v2_x; assign v2[1] = s_v2_y; assign v2[2] = s_v2_z;

    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] so_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= {v1[i][VW-1], v1[i]} - {v0[i][VW-1], v0[i]};
                e2_reg[i] <= {v2[i][VW-1], v2[i]} - {v0[i][VW-1], v0[i]};
                so_reg[i] <= {org[i][VW-1], org[i]} - {v0[i][VW-1], v0[i]};
            end
        end
    end

    // ---------------- stage 2: cross product terms ----------------
    logic signed [CW1-1:0] ca_reg [3];
    logic signed [CW1-1:0] cb_reg [3];
    logic signed [CW2-1:0] sa_reg [3];
    logic signed [CW2-1:0] sb_reg [3];
    logic signed [EW-1:0]  e1_2_reg [3];
    logic signed [EW-1:0]  e2_2_reg [3];
    logic signed [EW-1:0]  so_2_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                // s1 = d x e2, s2 = s x e1
                ca_reg[i] <= dir[(i+1)%3] * e2_reg[(i+2)%3];
                cb_reg[i] <= dir[(i+2)%3] * e2_reg[(i+1)%3];
                sa_reg[i] <= so_reg[(i+1)%3] * e1_reg[(i+2)%3];
                sb_reg[i] <= so_reg[(i+2)%3] * e1_reg[(i+1)%3];
                e1_2_reg[i] <= e1_reg[i];
                e2_2_reg[i] <= e2_reg[i];
                so_2_reg[i] <= so_reg[i];
            end
        end
    end

    // ---------------- stage 3: cross products ----------------
    logic signed [PW-1:0] s1_reg [3];
    logic signed [PW-1:0] s2_reg [3];
    logic signed [EW-1:0] e1_3_reg [3];
    logic signed [EW-1:0] e2_3_reg [3];
    logic signed [EW-1:0] so_3_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s1_reg[i] <= {{(PW-CW1){ca_reg[i][CW1-1]}}, ca_reg[i]}
                           - {{(PW-CW1){cb_reg[i][CW1-1]}}, cb_reg[i]};
                s2_reg[i] <= {sa_reg[i][CW2-1], sa_reg[i]} - {sb_reg[i][CW2-1], sb_reg[i]};
                e1_3_reg[i] <= e1_2_reg[i];
                e2_3_reg[i] <= e2_2_reg[i];
                so_3_reg[i] <= so_2_reg[i];
            end
        end
    end

    // ---------------- stage 4: split partial products ----------------
    logic signed [PW-1:0] pdl_reg [3];
    logic signed [PW-1:0] pdh_reg [3];
    logic signed [PW-1:0] pbl_reg [3];
    logic signed [PW-1:0] pbh_reg [3];
    logic signed [PW-1:0] pgl_reg [3];
    logic signed [PW-1:0] pgh_reg [3];
    logic signed [PW-1:0] ptl_reg [3];
    logic signed [PW-1:0] pth_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                pdl_reg[i] <= $signed({1'b0, s1_reg[i][EW-1:0]}) * e1_3_reg[i];
                pdh_reg[i] <= $signed(s1_reg[i][PW-1:EW]) * e1_3_reg[i];
                pbl_reg[i] <= $signed({1'b0, s1_reg[i][EW-1:0]}) * so_3_reg[i];
                pbh_reg[i] <= $signed(s1_reg[i][PW-1:EW]) * so_3_reg[i];
                pgl_reg[i] <= $signed({1'b0, s2_reg[i][EW-1:0]}) * dir[i];
                pgh_reg[i] <= $signed(s2_reg[i][PW-1:EW]) * dir[i];
                ptl_reg[i] <= $signed({1'b0, s2_reg[i][EW-1:0]}) * e2_3_reg[i];
                pth_reg[i] <= $signed(s2_reg[i][PW-1:EW]) * e2_3_reg[i];
            end
        end
    end

    // ---------------- stage 5: full products ----------------
    logic signed [DW-1:0] fd_reg [3];
    logic signed [DW-1:0] fb_reg [3];
    logic signed [DW-1:0] fg_reg [3];
    logic signed [DW-1:0] ft_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                fd_reg[i] <= join_pp(pdh_reg[i], pdl_reg[i]);
                fb_reg[i] <= join_pp(pbh_reg[i], pbl_reg[i]);
                fg_reg[i] <= join_pp(pgh_reg[i], pgl_reg[i]);
                ft_reg[i] <= join_pp(pth_reg[i], ptl_reg[i]);
            end
        end
    end

    // ---------------- stage 6: dot products ----------------
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] nb_reg;
    logic signed [DW-1:0] ng_reg;
    logic signed [DW-1:0] nt_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_reg <= fd_reg[0] + fd_reg[1] + fd_reg[2];
            nb_reg  <= fb_reg[0] + fb_reg[1] + fb_reg[2];
            ng_reg  <= fg_reg[0] + fg_reg[1] + fg_reg[2];
            nt_reg  <= ft_reg[0] + ft_reg[1] + ft_reg[2];
        end
    end

    // ---------------- stage 7: make the determinant positive ----------------
    logic signed [DW-1:0] det_7_reg;
    logic signed [DW-1:0] nb_7_reg;
    logic signed [DW-1:0] ng_7_reg;
    logic signed [DW-1:0] nt_7_reg;
    logic                 zero_7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            zero_7_reg <= (det_reg == '0);
            if (det_reg[DW-1]) begin
                det_7_reg <= -det_reg;
                nb_7_reg  <= -nb_reg;
                ng_7_reg  <= -ng_reg;
                nt_7_reg  <= -nt_reg;
            end else begin
                det_7_reg <= det_reg;
                nb_7_reg  <= nb_reg;
                ng_7_reg  <= ng_reg;
                nt_7_reg  <= nt_reg;
            end
        end
    end

    // ---------------- stage 8: range tests and divider set-up ----------------
    logic [RW-1:0]        trem_reg  [NDIV+1];
    logic [RW-1:0]        brem_reg  [NDIV+1];
    logic [RW-1:0]        grem_reg  [NDIV+1];
    logic [QB-1:0]        tq_reg    [NDIV+1];
    logic [BQB-1:0]       bq_reg    [NDIV+1];
    logic [BQB-1:0]       gq_reg    [NDIV+1];
    logic [DW-1:0]        ddet_reg  [NDIV+1];
    logic                 zero_reg  [NDIV+1];
    logic                 lneg_reg  [NDIV+1];
    logic                 ins_reg   [NDIV+1];
    logic                 ovf_reg   [NDIV+1];

    logic signed [DW:0]   bg_sum;
    logic signed [LW-1:0] lhs;
    logic [LW-1:0]        lmag;
    logic                 in_tri;
    logic [RW-1:0]        det_top;

    always_comb begin
        bg_sum  = {nb_7_reg[DW-1], nb_7_reg} + {ng_7_reg[DW-1], ng_7_reg};
        in_tri  = !nb_7_reg[DW-1] && !(nb_7_reg > det_7_reg) && !ng_7_reg[DW-1]
                  && !(bg_sum > {1'b0, det_7_reg});
        lhs     = {nt_7_reg, {FB{1'b0}}};
        lmag    = lhs[LW-1] ? LW'(-lhs) : LW'(lhs);
        det_top = {{(RW-DW){1'b0}}, det_7_reg} << QB;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvld_reg[0] <= 1'b0;
        end else if (adv) begin
            dvld_reg[0] <= vld_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            trem_reg[0] <= {{(RW-LW){1'b0}}, lmag};
            brem_reg[0] <= in_tri ? {{(RW-DW){1'b0}}, nb_7_reg} << BF : '0;
            grem_reg[0] <= in_tri ? {{(RW-DW){1'b0}}, ng_7_reg} << BF : '0;
            tq_reg[0]   <= '0;
            bq_reg[0]   <= '0;
            gq_reg[0]   <= '0;
            ddet_reg[0] <= det_7_reg;
            zero_reg[0] <= zero_7_reg;
            lneg_reg[0] <= lhs[LW-1];
            ins_reg[0]  <= in_tri;
            ovf_reg[0]  <= ({{(RW-LW){1'b0}}, lmag} >= det_top);
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        localparam int TB = QB - 1 - k;
        logic [RW-1:0]  dsh;
        logic [RW-1:0]  trem_next;
        logic [QB-1:0]  tq_next;
        logic [RW-1:0]  brem_next;
        logic [RW-1:0]  grem_next;
        logic [BQB-1:0] bq_next;
        logic [BQB-1:0] gq_next;

        always_comb begin
            dsh = {{(RW-DW){1'b0}}, ddet_reg[k]} << TB;
            if (trem_reg[k] >= dsh) begin
                trem_next = trem_reg[k] - dsh;
                tq_next   = {tq_reg[k][QB-2:0], 1'b1};
            end else begin
                trem_next = trem_reg[k];
                tq_next   = {tq_reg[k][QB-2:0], 1'b0};
            end
        end

        if (k < BQB) begin : g_bary
            localparam int BB = BQB - 1 - k;
            logic [RW-1:0] bsh;
            always_comb begin
                bsh = {{(RW-DW){1'b0}}, ddet_reg[k]} << BB;
                if (brem_reg[k] >= bsh) begin
                    brem_next = brem_reg[k] - bsh;
                    bq_next   = {bq_reg[k][BQB-2:0], 1'b1};
                end else begin
                    brem_next = brem_reg[k];
                    bq_next   = {bq_reg[k][BQB-2:0], 1'b0};
                end
                if (grem_reg[k] >= bsh) begin
                    grem_next = grem_reg[k] - bsh;
                    gq_next   = {gq_reg[k][BQB-2:0], 1'b1};
                end else begin
                    grem_next = grem_reg[k];
                    gq_next   = {gq_reg[k][BQB-2:0], 1'b0};
                end
            end
        end else begin : g_hold
            assign brem_next = brem_reg[k];
            assign grem_next = grem_reg[k];
            assign bq_next   = bq_reg[k];
            assign gq_next   = gq_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dvld_reg[k+1] <= dvld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                trem_reg[k+1] <= trem_next;
                tq_reg[k+1]   <= tq_next;
                brem_reg[k+1] <= brem_next;
                grem_reg[k+1] <= grem_next;
                bq_reg[k+1]   <= bq_next;
                gq_reg[k+1]   <= gq_next;
                ddet_reg[k+1] <= ddet_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                lneg_reg[k+1] <= lneg_reg[k];
                ins_reg[k+1]  <= ins_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end
    end

    // ---------------- window test, saturation, output register ----------------
    logic [QB-1:0]        q;
    logic                 rnz;
    logic signed [QB+1:0] fl;
    logic signed [QB+1:0] near_w;
    logic signed [QB+1:0] far_w;
    logic                 above_near;
    logic                 below_far;
    logic                 hit_next;
    logic signed [VW-1:0] dist_next;

    always_comb begin
        q      = tq_reg[NDIV];
        rnz    = (trem_reg[NDIV] != '0);
        near_w = {{(QB+2-VW){cfg_reg[rti_pkg::REG_T_NEAR][VW-1]}},
                  cfg_reg[rti_pkg::REG_T_NEAR]};
        far_w  = {{(QB+2-VW){cfg_reg[rti_pkg::REG_T_FAR][VW-1]}},
                  cfg_reg[rti_pkg::REG_T_FAR]};
        // floor of t
        if (lneg_reg[NDIV]) begin
            fl = -($signed({2'b00, q}) + $signed({{(QB+1){1'b0}}, rnz}));
        end else begin
            fl = $signed({2'b00, q});
        end
        if (ovf_reg[NDIV]) begin
            above_near = !lneg_reg[NDIV];
            below_far  = lneg_reg[NDIV];
        end else begin
            above_near = (fl > near_w) || ((fl == near_w) && rnz);
            below_far  = (fl < far_w);
        end
        hit_next = !zero_reg[NDIV] && ins_reg[NDIV] && above_near && below_far;
        if (zero_reg[NDIV]) begin
            dist_next = '0;
        end else if (lneg_reg[NDIV]) begin
            if (ovf_reg[NDIV] || q[QB-1] || (q[QB-2] && (q[QB-3:0] != '0))) begin
                dist_next = rti_pkg::DIST_MIN;
            end else begin
                dist_next = -$signed(q[VW-1:0]);
            end
        end else begin
            if (ovf_reg[NDIV] || q[QB-1] || q[QB-2]) begin
                dist_next = rti_pkg::DIST_MAX;
            end else begin
                dist_next = $signed(q[VW-1:0]);
            end
        end
    end

    logic                 m_hit_reg;
    logic                 m_degenerate_reg;
    logic signed [VW-1:0] m_hit_distance_reg;
    logic [BQB-1:0]       m_bary_beta_reg;
    logic [BQB-1:0]       m_bary_gamma_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dvld_reg[NDIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_hit_reg          <= hit_next;
            m_degenerate_reg   <= zero_reg[NDIV];
            m_hit_distance_reg <= dist_next;
            m_bary_beta_reg    <= hit_next ? bq_reg[NDIV] : '0;
            m_bary_gamma_reg   <= hit_next ? gq_reg[NDIV] : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_degenerate   = m_degenerate_reg;
    assign m_hit_distance = m_hit_distance_reg;
    assign m_bary_beta    = m_bary_beta_reg;
    assign m_bary_gamma   = m_bary_gamma_reg;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray / triangle intersection pipeline: triangles
// are streamed under several ray settings and idling patterns, and every
// result is checked against an exact wide-integer intersection predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int        VW        = rti_pkg::VW;
    localparam int        BW        = rti_pkg::BW;
    localparam int        CFG_NUM   = rti_pkg::CFG_NUM;
    localparam int        CFG_IDX_W = rti_pkg::CFG_IDX_W;
    localparam int        FRAC_BITS = rti_pkg::FRAC_BITS;
    localparam int        BARY_FRAC = rti_pkg::BARY_FRAC;
    localparam logic signed [VW-1:0] DIST_MAX  = rti_pkg::DIST_MAX;
    localparam logic signed [VW-1:0] DIST_MIN  = rti_pkg::DIST_MIN;
    localparam logic signed [VW-1:0] T_FAR_RST = rti_pkg::T_FAR_RST;
    localparam logic signed [VW-1:0] DIR_Z_RST = rti_pkg::DIR_Z_RST;

    localparam int        LIMIT  = 400000;
    localparam int        UNIT   = 65536;
    localparam int        SETTLE = 50;

    typedef logic signed [255:0] wint;
    typedef struct packed {
        logic signed [VW-1:0] x, y, z;
    } vec_t;
    typedef struct packed {
        vec_t v0, v1, v2;
    } tri_t;
    typedef struct packed {
        logic                 hit;
        logic                 degen;
        logic signed [VW-1:0] t_dist;
        logic [BW-1:0]        beta;
        logic [BW-1:0]        gamma;
    } isect_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [VW-1:0]           cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    tri_t                    s_tri;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_hit;
    logic                    m_degenerate;
    logic signed [VW-1:0]    m_hit_distance;
    logic [BW-1:0]           m_bary_beta;
    logic [BW-1:0]           m_bary_gamma;

    logic signed [VW-1:0]    ray_cfg [CFG_NUM];
    isect_t                  pending_isect[$];
    int                      mismatches;
    int                      send_idle_pct;
    int                      stall_pct;
    int                      hold_len;
    logic                    hold_go;
    logic                    hold_ack;
    int                      hold_cnt;
    int                      cycles;

    ray_triangle_intersect uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_v0_x         (s_tri.v0.x),
        .s_v0_y         (s_tri.v0.y),
        .s_v0_z         (s_tri.v0.z),
        .s_v1_x         (s_tri.v1.x),
        .s_v1_y         (s_tri.v1.y),
        .s_v1_z         (s_tri.v1.z),
        .s_v2_x         (s_tri.v2.x),
        .s_v2_y         (s_tri.v2.y),
        .s_v2_z         (s_tri.v2.z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_degenerate   (m_degenerate),
        .m_hit_distance (m_hit_distance),
        .m_bary_beta    (m_bary_beta),
        .m_bary_gamma   (m_bary_gamma)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic void cross3(input wint a[3], input wint b[3], output wint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic wint dot3(input wint a[3], input wint b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic isect_t intersect_triangle(input tri_t tr);
        wint    p0[3], p1[3], p2[3];
        wint    e1[3], e2[3], so[3], d[3], c1[3], c2[3];
        wint    det, nb, ng, nt, lhs, q, tn, tf;
        logic   in_tri, inwin;
        isect_t r;
        r = '0;
        p0[0] = wint'(signed'(tr.v0.x)); p0[1] = wint'(signed'(tr.v0.y));
        p0[2] = wint'(signed'(tr.v0.z));
        p1[0] = wint'(signed'(tr.v1.x)); p1[1] = wint'(signed'(tr.v1.y));
        p1[2] = wint'(signed'(tr.v1.z));
        p2[0] = wint'(signed'(tr.v2.x)); p2[1] = wint'(signed'(tr.v2.y));
        p2[2] = wint'(signed'(tr.v2.z));
        for (int i = 0; i < 3; i++) begin
            e1[i] = p1[i] - p0[i];
            e2[i] = p2[i] - p0[i];
            so[i] = wint'(ray_cfg[rti_pkg::REG_ORIGIN_X + i]) - p0[i];
            d[i]  = wint'(ray_cfg[rti_pkg::REG_DIR_X + i]);
        end
        cross3(d, e2, c1);
        cross3(so, e1, c2);
        det = dot3(c1, e1);
        nb  = dot3(c1, so);
        ng  = dot3(c2, d);
        nt  = dot3(c2, e2);
        if (det == 0) begin
            r.degen = 1'b1;
            return r;
        end
        if (det < 0) begin
            det = -det; nb = -nb; ng = -ng; nt = -nt;
        end
        tn = wint'(ray_cfg[rti_pkg::REG_T_NEAR]);
        tf = wint'(ray_cfg[rti_pkg::REG_T_FAR]);
        in_tri = (nb >= 0) && (nb <= det) && (ng >= 0) && (nb + ng <= det);
        lhs    = nt <<< FRAC_BITS;
        inwin  = (lhs > tn * det) && (tf * det > lhs);
        r.hit  = in_tri && inwin;
        q = lhs / det;   // truncates toward zero
        if (q > wint'(DIST_MAX))
            r.t_dist = DIST_MAX;
        else if (q < wint'(DIST_MIN))
            r.t_dist = DIST_MIN;
        else
            r.t_dist = q[VW-1:0];
        if (r.hit) begin
            q = (nb <<< BARY_FRAC) / det;
            r.beta = q[BW-1:0];
            q = (ng <<< BARY_FRAC) / det;
            r.gamma = q[BW-1:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking
    always @(posedge aclk) begin
        isect_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_hit, m_degenerate, m_hit_distance, m_bary_beta, m_bary_gamma};
            if (pending_isect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit=%0b degen=%0b t=%0d b=%0d g=%0d",
                             got.hit, got.degen, got.t_dist, got.beta, got.gamma);
            end else begin
                want = pending_isect.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp hit=%0b degen=%0b t=%0d b=%0d g=%0d",
                                  " | got %0b %0b %0d %0d %0d"},
                                 want.hit, want.degen, want.t_dist, want.beta, want.gamma,
                                 got.hit, got.degen, got.t_dist, got.beta, got.gamma);
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_cnt <= 0;
            hold_ack <= 1'b0;
        end else if (hold_go != hold_ack) begin
            hold_ack <= hold_go;
            hold_cnt <= hold_len;
            m_ready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers
    task automatic send_triangle(input tri_t tr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_tri   <= tr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_isect.push_back(intersect_triangle(tr));
    endtask

    task automatic write_reg(input rti_pkg::cfg_reg_t idx, input logic signed [VW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        ray_cfg[idx] = val;
    endtask

    task automatic drain();
        s_valid   <= 1'b0;
        cfg_wr_en <= 1'b0;
        while (pending_isect.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic signed [VW-1:0] rand_scaled(input int bits);
        return VW'(longint'(signed'($urandom)) >>> (31 - bits));
    endfunction

    // ray near the origin, short direction, a window around the useful range
    task automatic random_ray();
        for (int i = 0; i < 3; i++) begin
            write_reg(rti_pkg::cfg_reg_t'(rti_pkg::REG_ORIGIN_X + i),
                      rand_scaled($urandom_range(4, 22)));
            write_reg(rti_pkg::cfg_reg_t'(rti_pkg::REG_DIR_X + i),
                      ($urandom_range(3) == 0) ? '0 : rand_scaled($urandom_range(8, 18)));
        end
        write_reg(rti_pkg::REG_T_NEAR, ($urandom_range(1) == 0) ? '0 : rand_scaled(20));
        write_reg(rti_pkg::REG_T_FAR, ($urandom_range(2) == 0) ? T_FAR_RST
                                      : VW'($urandom_range(2, 10) * UNIT));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [VW-1:0] near_axis(input longint c);
        return VW'(c + longint'(rand_scaled($urandom_range(4, 20))));
    endfunction

    function automatic tri_t random_triangle();
        tri_t   tr;
        longint c[3];
        int     k, sel;
        sel = $urandom_range(99);
        k   = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
            c[i] = longint'(ray_cfg[rti_pkg::REG_ORIGIN_X + i])
                 + longint'(ray_cfg[rti_pkg::REG_DIR_X + i]) * k;
        if (sel < 70) begin
            // aimed at a point on the ray
            tr.v0 = '{near_axis(c[0]), near_axis(c[1]), near_axis(c[2])};
            tr.v1 = '{near_axis(c[0]), near_axis(c[1]), near_axis(c[2])};
            tr.v2 = '{near_axis(c[0]), near_axis(c[1]), near_axis(c[2])};
        end else if (sel < 90) begin
            tr = {$urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
        end else begin
            // flat: repeated vertex
            tr.v0 = '{near_axis(c[0]), near_axis(c[1]), near_axis(c[2])};
            tr.v1 = '{near_axis(c[0]), near_axis(c[1]), near_axis(c[2])};
            tr.v2 = ($urandom_range(1) == 0) ? tr.v0 : tr.v1;
        end
        return tr;
    endfunction

    function automatic tri_t unit_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        tri_t tr;
        tr.v0 = '{VW'(ax * UNIT), VW'(ay * UNIT), VW'(az * UNIT)};
        tr.v1 = '{VW'(bx * UNIT), VW'(by * UNIT), VW'(bz * UNIT)};
        tr.v2 = '{VW'(cx * UNIT), VW'(cy * UNIT), VW'(cz * UNIT)};
        return tr;
    endfunction

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_triangle(unit_tri(-1, -1, 5, 2, -1, 5, -1, 2, 5));   // plain hit
        send_triangle(unit_tri(-1, -1, 5, -1, 2, 5, 2, -1, 5));   // opposite winding
        send_triangle(unit_tri(3, 3, 5, 4, 3, 5, 3, 4, 5));       // outside
        send_triangle(unit_tri(1, 1, 1, 1, 1, 1, 1, 1, 1));       // single point
        send_triangle(unit_tri(0, -1, 1, 0, 1, 1, 0, 0, 3));      // parallel to ray
        send_triangle(unit_tri(-1, -1, -5, 2, -1, -5, -1, 2, -5)); // behind origin
        send_triangle(unit_tri(0, 0, 4, 1, 0, 4, 0, 1, 4));       // through first vertex
        send_triangle(unit_tri(-1, 0, 4, 0, 0, 4, -1, 1, 4));     // through second vertex
        send_triangle(unit_tri(-1, -1, 4, 1, 1, 4, -1, 1, 4));    // on an edge
        send_triangle({9{DIST_MAX}});
        send_triangle({9{DIST_MIN}});
        send_triangle({DIST_MIN, DIST_MIN, DIST_MIN, DIST_MAX, DIST_MIN, DIST_MAX,
                       DIST_MIN, DIST_MAX, DIST_MAX});
        send_triangle({DIST_MAX, 32'sd0, DIST_MIN, DIST_MIN, DIST_MAX, 32'sd0,
                       32'sd0, DIST_MIN, DIST_MAX});
        drain();
        // distance exactly on the near bound is outside the open window
        write_reg(rti_pkg::REG_T_NEAR, VW'(5 * UNIT));
        cfg_wr_en <= 1'b0;
        drain();
        send_triangle(unit_tri(-1, -1, 5, 2, -1, 5, -1, 2, 5));
        send_triangle(unit_tri(-1, -1, 6, 2, -1, 6, -1, 2, 6));
        drain();
        // tiny direction: t far beyond the 32-bit range saturates
        write_reg(rti_pkg::REG_T_NEAR, DIST_MIN);
        write_reg(rti_pkg::REG_DIR_Z, 32'sd1);
        cfg_wr_en <= 1'b0;
        drain();
        send_triangle(unit_tri(-1, -1, 5, 2, -1, 5, -1, 2, 5));
        send_triangle(unit_tri(-1, -1, -5, 2, -1, -5, -1, 2, -5));
        drain();
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        random_ray();
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 39) begin
                drain();
                random_ray();
            end
            send_triangle(random_triangle());
        end
        drain();
    endtask

    task automatic test_register_extremes();
        send_idle_pct = 10;
        stall_pct     = 10;
        for (int i = 0; i < 3; i++) begin
            write_reg(rti_pkg::cfg_reg_t'(rti_pkg::REG_ORIGIN_X + i), DIST_MIN);
            write_reg(rti_pkg::cfg_reg_t'(rti_pkg::REG_DIR_X + i), DIST_MAX);
        end
        write_reg(rti_pkg::REG_T_NEAR, DIST_MIN);
        write_reg(rti_pkg::REG_T_FAR, DIST_MAX);
        cfg_wr_en <= 1'b0;
        drain();
        for (int i = 0; i < 20; i++) send_triangle(random_triangle());
        drain();
        for (int i = 0; i < 3; i++) begin
            write_reg(rti_pkg::cfg_reg_t'(rti_pkg::REG_ORIGIN_X + i), DIST_MAX);
            write_reg(rti_pkg::cfg_reg_t'(rti_pkg::REG_DIR_X + i), DIST_MIN);
        end
        write_reg(rti_pkg::REG_T_NEAR, DIST_MAX);
        write_reg(rti_pkg::REG_T_FAR, DIST_MIN);
        cfg_wr_en <= 1'b0;
        drain();
        for (int i = 0; i < 20; i++) send_triangle(random_triangle());
        drain();
    endtask

    task automatic test_backpressure();
        random_ray();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_len = 400;
        hold_go  = ~hold_go;
        for (int i = 0; i < 60; i++) send_triangle(random_triangle());
        // sender pauses until the pipe is empty, then resumes
        s_valid <= 1'b0;
        while (pending_isect.size() != 0) @(posedge aclk);
        for (int i = 0; i < 30; i++) send_triangle(random_triangle());
        drain();
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_tri         = '0;
        hold_go       = 1'b0;
        hold_len      = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        ray_cfg       = '{default: '0};
        ray_cfg[rti_pkg::REG_DIR_Z] = DIR_Z_RST;
        ray_cfg[rti_pkg::REG_T_FAR] = T_FAR_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(120, 0, 0);
        test_random(100, 77, 0);
        test_random(100, 0, 77);
        test_random(100, 26, 26);
        test_register_extremes();
        test_backpressure();

        if (mismatches == 0 && pending_isect.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
